// ===== rtl/fcti_pkg.sv =====
// ----------------------------------------------------------------------------
// fcti_pkg: shared types and constants
// Payload structs, command/status bundles and fixed constants of the
// calibration table interpolator.
// ----------------------------------------------------------------------------
package fcti_pkg;

   // table layout
   localparam int NUM_TABLES       = 9;
   localparam int NUM_POWER_TABLES = 4;
   localparam int DEF_VHF_POINTS   = 5;
   localparam int DEF_UHF_POINTS   = 9;
   localparam int IDX_W            = 4;
   localparam int SEL_W            = 4;

   // frequency arithmetic
   localparam int FREQ_W   = 27;
   localparam int STEP_W   = 20;
   localparam int QUOT_W   = 14;
   localparam int VAL_W    = 12;
   localparam int PROD_W   = 32;
   localparam int DIV_W    = PROD_W;
   localparam int RES_W    = 16;

   localparam logic [FREQ_W-1:0] BAND_SPLIT = FREQ_W'(30000000);
   localparam logic [STEP_W-1:0] UHF_STEP   = STEP_W'(1000000);
   localparam logic [STEP_W-1:0] VHF_STEP   = STEP_W'(950000);
   localparam logic [12:0]       POWER_MAX  = 13'd4096;
   localparam logic [12:0]       TUNE_MAX   = 13'd4095;
   localparam logic [12:0]       GAIN_MAX   = 13'd255;

   // reciprocals of the point spacings, scaled by 2^RECIP_SH
   localparam int               RECIP_W   = 32;
   localparam int               RECIP_SH  = 51;
   localparam logic [63:0]      RECIP_ONE = 64'd1 << RECIP_SH;
   localparam logic [RECIP_W-1:0] UHF_RECIP = RECIP_W'(RECIP_ONE / 64'(UHF_STEP));
   localparam logic [RECIP_W-1:0] VHF_RECIP = RECIP_W'(RECIP_ONE / 64'(VHF_STEP));

   // operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_POWER  = 2'd2;
   localparam logic [1:0] OP_SINGLE = 2'd3;

   // table codes
   localparam logic [SEL_W-1:0] TBL_RX_TUNE = 4'd4;
   localparam logic [SEL_W-1:0] TBL_DMR_Q   = 4'd8;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_UHF_IQ_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VHF_IQ_BASE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UHF_POWER_BASE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VHF_POWER_BASE = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [SEL_W-1:0]  table_select;
      logic [IDX_W-1:0]  point_index;
      logic [7:0]        write_value;
      logic [FREQ_W-1:0] frequency;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_value;
      logic [11:0] lookup_value;
      logic [12:0] very_low_power;
      logic [12:0] low_power;
      logic [12:0] mid_power;
      logic [12:0] high_power;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic clear_write;
      logic mem_write;
      logic mem_read_pt;
      logic take_read;
      logic div_start_d;
      logic take_index;
      logic mem_read_lo;
      logic mem_read_hi;
      logic take_lower;
      logic take_other;
      logic mul;
      logic div_start_p;
      logic take_result;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] operation;
      logic       single_ok;
      logic       div_busy;
      logic       last_table;
      logic       out_free;
   } status_type;

endpackage

// ===== rtl/fcti_divider.sv =====
// ----------------------------------------------------------------------------
// fcti_divider: divide by the point spacing
// Unsigned divide by one of the two spacing constants: reciprocal multiply,
// back-multiply, then one compare and subtract; busy from start until the result is registered.
// ----------------------------------------------------------------------------
module fcti_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fcti_pkg::DIV_W-1:0] dividend,
   input  logic [fcti_pkg::STEP_W-1:0] divisor,
   output logic                       busy,
   output logic [fcti_pkg::QUOT_W-1:0] quot,
   output logic [fcti_pkg::DIV_W-1:0] rem
);
   import fcti_pkg::*;

   localparam int WIDE_W = DIV_W + RECIP_W;
   localparam int QS_W   = DIV_W + 1;

   localparam logic [1:0] PH_MUL  = 2'd0;
   localparam logic [1:0] PH_BACK = 2'd1;
   localparam logic [1:0] PH_FIX  = 2'd2;

   logic [DIV_W-1:0]   x_ff, x_in;
   logic [STEP_W-1:0]  dvs_ff, dvs_in;
   logic [RECIP_W-1:0] recip_ff, recip_in;
   logic [WIDE_W-1:0]  prod_ff, prod_in;
   logic [QUOT_W-1:0]  q_ff, q_in;
   logic [QS_W-1:0]    qs_ff, qs_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [1:0]         phase_ff, phase_in;
   logic               busy_ff, busy_in;
   logic [RECIP_W-1:0] recip_sel;
   logic [QUOT_W-1:0]  q_est;
   logic [QS_W-1:0]    r_full;

   // estimate is exact or one low; the last phase corrects it
   always_comb begin
      recip_sel = (divisor == UHF_STEP) ? UHF_RECIP : VHF_RECIP;
      q_est     = QUOT_W'(prod_ff >> RECIP_SH);
      r_full    = QS_W'(x_ff) - qs_ff;
      x_in      = x_ff;
      dvs_in    = dvs_ff;
      recip_in  = recip_ff;
      prod_in   = prod_ff;
      q_in      = q_ff;
      qs_in     = qs_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      phase_in  = phase_ff;
      busy_in   = busy_ff;
      if (start) begin
         x_in     = dividend;
         dvs_in   = divisor;
         recip_in = recip_sel;
         phase_in = PH_MUL;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_MUL: begin
               prod_in  = WIDE_W'(x_ff) * WIDE_W'(recip_ff);
               phase_in = PH_BACK;
            end
            PH_BACK: begin
               q_in     = q_est;
               qs_in    = QS_W'(q_est) * QS_W'(dvs_ff);
               phase_in = PH_FIX;
            end
            default: begin
               if (r_full >= QS_W'(dvs_ff)) begin
                  quot_in = q_ff + 1'b1;
                  rem_in  = DIV_W'(r_full - QS_W'(dvs_ff));
               end else begin
                  quot_in = q_ff;
                  rem_in  = DIV_W'(r_full);
               end
               phase_in = PH_MUL;
               busy_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_MUL;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      x_ff     <= x_in;
      dvs_ff   <= dvs_in;
      recip_ff <= recip_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      qs_ff    <= qs_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/fcti_datapath.sv =====
// ----------------------------------------------------------------------------
// fcti_datapath: point store, segment arithmetic and result registers
// Executes the controller's commands: store access, band and segment
// selection, slope multiply, shared divider and clamping.
// ----------------------------------------------------------------------------
module fcti_datapath #(
   parameter int VHF_POINTS = fcti_pkg::DEF_VHF_POINTS,
   parameter int UHF_POINTS = fcti_pkg::DEF_UHF_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fcti_pkg::cmd_type             cmd,
   output fcti_pkg::status_type          status,
   input  fcti_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fcti_pkg::rsp_type             rsp_data,
   input  logic                          csr_write,
   input  logic [fcti_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fcti_pkg::FREQ_W-1:0]   csr_data
);
   import fcti_pkg::*;

   localparam int TABLE_LEN = VHF_POINTS + UHF_POINTS;
   localparam int DEPTH     = NUM_TABLES * TABLE_LEN;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CALC_W    = ADDR_W + SEL_W + 1;

   // configuration registers
   logic [FREQ_W-1:0] uhf_iq_ff, vhf_iq_ff, uhf_pwr_ff, vhf_pwr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         uhf_iq_ff  <= '0;
         vhf_iq_ff  <= '0;
         uhf_pwr_ff <= '0;
         vhf_pwr_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_UHF_IQ_BASE:    uhf_iq_ff  <= csr_data;
            CSR_VHF_IQ_BASE:    vhf_iq_ff  <= csr_data;
            CSR_UHF_POWER_BASE: uhf_pwr_ff <= csr_data;
            CSR_VHF_POWER_BASE: vhf_pwr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // captured item and working registers
   req_type             req_ff;
   logic [SEL_W-1:0]    tbl_ff;
   logic                uhf_ff, d_neg_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [STEP_W-1:0]   off_ff;
   logic [VAL_W-1:0]    lower_ff, other_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic                prod_neg_ff;
   rsp_type             work_ff, rsp_ff;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic [7:0]          rd_ff;

   // band and distance from the band start
   logic              uhf_sel;
   logic [FREQ_W-1:0] base_sel;
   logic [STEP_W-1:0] step_sel;
   logic              d_neg;
   logic [FREQ_W-1:0] d_mag;

   always_comb begin
      uhf_sel = req_ff.frequency > BAND_SPLIT;
      if (req_ff.operation == OP_POWER) base_sel = uhf_sel ? uhf_pwr_ff : vhf_pwr_ff;
      else                              base_sel = uhf_sel ? uhf_iq_ff : vhf_iq_ff;
      step_sel = (uhf_sel || req_ff.operation == OP_POWER) ? UHF_STEP : VHF_STEP;
      d_neg    = req_ff.frequency < base_sel;
      d_mag    = d_neg ? base_sel - req_ff.frequency : req_ff.frequency - base_sel;
   end

   // shared divider
   logic              div_start, div_busy;
   logic [DIV_W-1:0]  div_dividend;
   logic [STEP_W-1:0] div_divisor;
   logic [QUOT_W-1:0] div_quot;
   logic [DIV_W-1:0]  div_rem;

   assign div_start    = cmd.div_start_d || cmd.div_start_p;
   assign div_dividend = cmd.div_start_d ? DIV_W'(d_mag) : DIV_W'(prod_ff);
   assign div_divisor  = cmd.div_start_d ? step_sel : step_ff;

   fcti_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // segment index and neighbor point
   logic [IDX_W-1:0] last_idx, other_idx, idx_new;
   logic [CALC_W-1:0] first_pt;
   logic              at_top;

   always_comb begin
      last_idx  = uhf_ff ? IDX_W'(UHF_POINTS - 1) : IDX_W'(VHF_POINTS - 1);
      first_pt  = uhf_ff ? CALC_W'(VHF_POINTS) : '0;
      at_top    = idx_ff == last_idx;
      other_idx = at_top ? idx_ff - 1'b1 : idx_ff + 1'b1;
      if (d_neg_ff)                            idx_new = '0;
      else if (div_quot > QUOT_W'(last_idx))   idx_new = last_idx;
      else                                     idx_new = div_quot[IDX_W-1:0];
   end

   // store addresses
   logic [CALC_W-1:0] row_base, pt_calc;
   logic [ADDR_W-1:0] pt_addr, lo_addr, hi_addr, mem_addr;
   logic              rw_ok;

   always_comb begin
      rw_ok    = (req_ff.table_select <= TBL_DMR_Q)
                 && (CALC_W'(req_ff.point_index) < CALC_W'(TABLE_LEN));
      pt_calc  = CALC_W'(req_ff.table_select) * CALC_W'(TABLE_LEN)
                 + CALC_W'(req_ff.point_index);
      pt_addr  = pt_calc[ADDR_W-1:0];
      row_base = CALC_W'(tbl_ff) * CALC_W'(TABLE_LEN) + first_pt;
      lo_addr  = ADDR_W'(row_base + CALC_W'(idx_ff));
      hi_addr  = ADDR_W'(row_base + CALC_W'(other_idx));
      if (cmd.clear_write)      mem_addr = clr_ff;
      else if (cmd.mem_read_lo) mem_addr = lo_addr;
      else if (cmd.mem_read_hi) mem_addr = hi_addr;
      else                      mem_addr = pt_addr;
   end

   // point store with registered read
   logic [7:0] mem [DEPTH];
   logic       mem_we;
   logic [7:0] mem_wdata;

   assign mem_we    = cmd.clear_write || (cmd.mem_write && rw_ok);
   assign mem_wdata = cmd.clear_write ? 8'd0 : req_ff.write_value;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[mem_addr];
   end

   // scaled point, slope and interpolated result
   logic              scale16;
   logic [VAL_W-1:0]  rd_scaled;
   logic [VAL_W:0]    diff;
   logic              diff_neg;
   logic [VAL_W-1:0]  diff_mag;
   logic [12:0]       maxv;
   logic signed [RES_W-1:0] q_signed, r_sum;
   logic [12:0]       r_clamp;

   always_comb begin
      scale16   = tbl_ff <= TBL_RX_TUNE;
      rd_scaled = scale16 ? {rd_ff, 4'd0} : {4'd0, rd_ff};
      diff      = at_top ? {1'b0, lower_ff} - {1'b0, other_ff}
                         : {1'b0, other_ff} - {1'b0, lower_ff};
      diff_neg  = diff[VAL_W];
      diff_mag  = diff_neg ? VAL_W'(-diff) : diff[VAL_W-1:0];
      if (tbl_ff < TBL_RX_TUNE)       maxv = POWER_MAX;
      else if (tbl_ff == TBL_RX_TUNE) maxv = TUNE_MAX;
      else                            maxv = GAIN_MAX;
      q_signed = $signed(RES_W'(div_quot));
      if (prod_neg_ff) q_signed = -q_signed;
      r_sum = $signed(RES_W'(lower_ff)) + q_signed;
      if (r_sum < 0)                           r_clamp = '0;
      else if (r_sum > $signed(RES_W'(maxv)))  r_clamp = maxv;
      else                                     r_clamp = r_sum[12:0];
   end

   // control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_write) clr_ff <= clr_ff + 1'b1;
         if (cmd.out_load)    rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff  <= req_data;
         work_ff <= '0;
         tbl_ff  <= (req_data.operation == OP_POWER) ? '0 : req_data.table_select;
      end
      if (cmd.take_read) work_ff.read_value <= rw_ok ? rd_ff : 8'd0;
      if (cmd.div_start_d) begin
         uhf_ff   <= uhf_sel;
         step_ff  <= step_sel;
         d_neg_ff <= d_neg;
      end
      if (cmd.take_index) begin
         idx_ff <= idx_new;
         off_ff <= div_rem[STEP_W-1:0];
      end
      if (cmd.take_lower) lower_ff <= rd_scaled;
      if (cmd.take_other) other_ff <= rd_scaled;
      if (cmd.mul) begin
         prod_ff     <= PROD_W'(diff_mag) * PROD_W'(off_ff);
         prod_neg_ff <= diff_neg ^ d_neg_ff;
      end
      if (cmd.take_result) begin
         if (req_ff.operation == OP_SINGLE) begin
            work_ff.lookup_value <= r_clamp[11:0];
         end else begin
            case (tbl_ff[1:0])
               2'd0:    work_ff.very_low_power <= r_clamp;
               2'd1:    work_ff.low_power      <= r_clamp;
               2'd2:    work_ff.mid_power      <= r_clamp;
               default: work_ff.high_power     <= r_clamp;
            endcase
            tbl_ff <= tbl_ff + 1'b1;
         end
      end
      if (cmd.out_load) rsp_ff <= work_ff;
   end

   // status to the controller
   always_comb begin
      status.clear_last = clr_ff == ADDR_W'(DEPTH - 1);
      status.operation  = req_ff.operation;
      status.single_ok  = (req_ff.table_select >= TBL_RX_TUNE)
                          && (req_ff.table_select <= TBL_DMR_Q);
      status.div_busy   = div_busy;
      status.last_table = (req_ff.operation == OP_SINGLE)
                          || (tbl_ff == SEL_W'(NUM_POWER_TABLES - 1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy) else $error("divider started while busy");
   a_index_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.take_index |-> !div_busy) else $error("index taken before quotient");
   a_result_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.take_result |-> !div_busy) else $error("result taken before quotient");
   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall)) else $error("result overwritten");
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff) else $error("loaded result not shown");

endmodule

// ===== rtl/fcti_controller.sv =====
// ----------------------------------------------------------------------------
// fcti_controller: sequencing state machine
// Clears the store after reset, accepts one item and steps the datapath
// through the access, divide and interpolate sequence.
// ----------------------------------------------------------------------------
module fcti_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fcti_pkg::status_type status,
   output fcti_pkg::cmd_type    cmd
);
   import fcti_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DISPATCH  = 4'd2;
   localparam logic [3:0] S_WRITE     = 4'd3;
   localparam logic [3:0] S_READ      = 4'd4;
   localparam logic [3:0] S_READ_WAIT = 4'd5;
   localparam logic [3:0] S_DSTART    = 4'd6;
   localparam logic [3:0] S_DWAIT     = 4'd7;
   localparam logic [3:0] S_RD_LO     = 4'd8;
   localparam logic [3:0] S_RD_HI     = 4'd9;
   localparam logic [3:0] S_RD_WAIT   = 4'd10;
   localparam logic [3:0] S_MUL       = 4'd11;
   localparam logic [3:0] S_PSTART    = 4'd12;
   localparam logic [3:0] S_PWAIT     = 4'd13;
   localparam logic [3:0] S_DONE      = 4'd14;

   logic [3:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (status.operation)
               OP_WRITE: state_in = S_WRITE;
               OP_READ:  state_in = S_READ;
               OP_POWER: state_in = S_DSTART;
               default:  state_in = status.single_ok ? S_DSTART : S_DONE;
            endcase
         end
         S_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = S_DONE;
         end
         S_READ: begin
            cmd.mem_read_pt = 1'b1;
            state_in        = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            cmd.take_read = 1'b1;
            state_in      = S_DONE;
         end
         S_DSTART: begin
            cmd.div_start_d = 1'b1;
            state_in        = S_DWAIT;
         end
         S_DWAIT: begin
            if (!status.div_busy) begin
               cmd.take_index = 1'b1;
               state_in       = S_RD_LO;
            end
         end
         S_RD_LO: begin
            cmd.mem_read_lo = 1'b1;
            state_in        = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.mem_read_hi = 1'b1;
            cmd.take_lower  = 1'b1;
            state_in        = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            cmd.take_other = 1'b1;
            state_in       = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_PSTART;
         end
         S_PSTART: begin
            cmd.div_start_p = 1'b1;
            state_in        = S_PWAIT;
         end
         S_PWAIT: begin
            if (!status.div_busy) begin
               cmd.take_result = 1'b1;
               state_in        = status.last_table ? S_DONE : S_RD_LO;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

// ===== rtl/freq_cal_table_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// freq_cal_table_interpolator_unit: calibration table interpolator
// Serves writes, reads, single lookups and power lookups; a single lookup on
// a table without lookup goes straight to the response. One item in work at
// a time; the next request can transfer on the edge of the response transfer.
// Reset clears the control and configuration registers, then a clearing pass
// zeros the point store while req_stall stays high.
// ----------------------------------------------------------------------------
module freq_cal_table_interpolator_unit #(
   parameter int VHF_POINTS = fcti_pkg::DEF_VHF_POINTS,
   parameter int UHF_POINTS = fcti_pkg::DEF_UHF_POINTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  fcti_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output fcti_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fcti_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fcti_pkg::FREQ_W-1:0]    csr_data
);
   import fcti_pkg::*;

   cmd_type    cmd;
   status_type status;

   // register writes always land
   assign csr_ready = 1'b1;

   fcti_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fcti_datapath #(
      .VHF_POINTS (VHF_POINTS),
      .UHF_POINTS (UHF_POINTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
